FILE: rtl/pdc_pkg.sv
// Shared types and constants for the profile difference classifier.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package pdc_pkg;

    localparam int MAX_THRESHOLDS = 4;
    localparam int ENERGY_BITS    = 16;

    localparam int SUM_BITS       = 24;
    localparam int MINREF_BITS    = 16;
    localparam int COUNT_BITS     = 3;
    localparam int CAT_BITS       = 3;
    localparam int NUM_THR_REGS   = 4;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;

    // Thresholds that can actually be in use.
    localparam int THR_USED = (MAX_THRESHOLDS < NUM_THR_REGS) ? MAX_THRESHOLDS : NUM_THR_REGS;

    // Width for comparing a reference energy against the minimum.
    localparam int CMP_BITS = (ENERGY_BITS > MINREF_BITS) ? ENERGY_BITS : MINREF_BITS;

    // Width of the unsaturated sum: one carry bit above the wider operand.
    localparam int ACC_BITS = ((ENERGY_BITS > SUM_BITS) ? ENERGY_BITS : SUM_BITS) + 1;

    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_REFERENCE   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD_COUNT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD_A     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD_B     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD_C     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD_D     = 3'd5;

    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 3'd4;

    // Configuration as seen by the datapath; thr_in_use is already clamped.
    typedef struct packed {
        logic [MINREF_BITS-1:0]                  min_reference;
        logic [COUNT_BITS-1:0]                   thr_in_use;
        logic [NUM_THR_REGS-1:0][SUM_BITS-1:0]   thresholds;
    } cfg_t;

    // Finished sum of one shower, waiting for classification.
    typedef struct packed {
        logic                valid;
        logic [SUM_BITS-1:0] total;
    } pend_t;

endpackage

`default_nettype wire

FILE: rtl/pdc_cfg.sv
// Configuration register file of the profile difference classifier.
// Depends on pdc_pkg; presents the registers as one pdc_pkg::cfg_t.
`default_nettype none

module pdc_cfg (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [pdc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [pdc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output pdc_pkg::cfg_t                             cfg
);

    logic [pdc_pkg::MINREF_BITS-1:0]                          min_reference_reg;
    logic [pdc_pkg::COUNT_BITS-1:0]                           threshold_count_reg;
    logic [pdc_pkg::NUM_THR_REGS-1:0][pdc_pkg::SUM_BITS-1:0]  thresholds_reg;
    logic [pdc_pkg::COUNT_BITS-1:0]                           in_use;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reference_reg   <= '0;
            threshold_count_reg <= pdc_pkg::COUNT_RESET;
            thresholds_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pdc_pkg::CFG_MIN_REFERENCE:
                    min_reference_reg <= cfg_data[pdc_pkg::MINREF_BITS-1:0];
                pdc_pkg::CFG_THRESHOLD_COUNT:
                    threshold_count_reg <= cfg_data[pdc_pkg::COUNT_BITS-1:0];
                pdc_pkg::CFG_THRESHOLD_A:
                    thresholds_reg[0] <= cfg_data[pdc_pkg::SUM_BITS-1:0];
                pdc_pkg::CFG_THRESHOLD_B:
                    thresholds_reg[1] <= cfg_data[pdc_pkg::SUM_BITS-1:0];
                pdc_pkg::CFG_THRESHOLD_C:
                    thresholds_reg[2] <= cfg_data[pdc_pkg::SUM_BITS-1:0];
                pdc_pkg::CFG_THRESHOLD_D:
                    thresholds_reg[3] <= cfg_data[pdc_pkg::SUM_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // A count of zero means one threshold; larger counts clamp to what exists.
    always_comb
    begin
        in_use = threshold_count_reg;
        if (in_use == '0)
            in_use = pdc_pkg::COUNT_BITS'(1);
        if (in_use > pdc_pkg::COUNT_BITS'(pdc_pkg::THR_USED))
            in_use = pdc_pkg::COUNT_BITS'(pdc_pkg::THR_USED);
    end

    assign cfg.min_reference = min_reference_reg;
    assign cfg.thr_in_use    = in_use;
    assign cfg.thresholds    = thresholds_reg;

endmodule

`default_nettype wire

FILE: rtl/pdc_accum.sv
// Input register and saturating accumulator of absolute layer differences.
// Depends on pdc_pkg; hands each finished shower sum on as a pdc_pkg::pend_t.
`default_nettype none

module pdc_accum (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire pdc_pkg::cfg_t                      cfg,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [pdc_pkg::ENERGY_BITS-1:0]    measured_energy,
    input  wire logic [pdc_pkg::ENERGY_BITS-1:0]    reference_energy,
    input  wire logic                               last_layer,
    output pdc_pkg::pend_t                          pend,
    input  wire logic                               pend_ready
);

    logic                             s1_valid_reg, s1_valid_next;
    logic [pdc_pkg::ENERGY_BITS-1:0]  s1_meas_reg;
    logic [pdc_pkg::ENERGY_BITS-1:0]  s1_ref_reg;
    logic                             s1_last_reg;
    logic [pdc_pkg::SUM_BITS-1:0]     sum_reg, sum_next;
    logic                             pend_valid_reg, pend_valid_next;
    logic [pdc_pkg::SUM_BITS-1:0]     pend_total_reg;

    logic                             acc_fire;
    logic                             s1_free;
    logic                             in_take;
    logic                             layer_used;
    logic [pdc_pkg::ENERGY_BITS-1:0]  diff;
    logic [pdc_pkg::ACC_BITS-1:0]     sum_wide;
    logic [pdc_pkg::SUM_BITS-1:0]     sum_upd;

    // A non-last layer only touches the sum; a last layer also needs the pending slot.
    assign acc_fire = s1_valid_reg && (!s1_last_reg || pend_ready);
    assign s1_free  = !s1_valid_reg || acc_fire;
    assign in_stall = !s1_free;
    assign in_take  = in_valid && s1_free;

    always_comb
    begin
        layer_used = pdc_pkg::CMP_BITS'(s1_ref_reg) >= pdc_pkg::CMP_BITS'(cfg.min_reference);
        if (s1_ref_reg >= s1_meas_reg)
            diff = s1_ref_reg - s1_meas_reg;
        else
            diff = s1_meas_reg - s1_ref_reg;
        sum_wide = pdc_pkg::ACC_BITS'(sum_reg) + pdc_pkg::ACC_BITS'(diff);
        if (!layer_used)
            sum_upd = sum_reg;
        else if (sum_wide > pdc_pkg::ACC_BITS'(pdc_pkg::SUM_MAX))
            sum_upd = pdc_pkg::SUM_MAX;
        else
            sum_upd = sum_wide[pdc_pkg::SUM_BITS-1:0];
    end

    always_comb
    begin
        s1_valid_next   = in_take || (s1_valid_reg && !acc_fire);
        sum_next        = sum_reg;
        if (acc_fire)
            sum_next = s1_last_reg ? '0 : sum_upd;
        pend_valid_next = (acc_fire && s1_last_reg) || (pend_valid_reg && !pend_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            sum_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            sum_reg        <= sum_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_meas_reg <= measured_energy;
            s1_ref_reg  <= reference_energy;
            s1_last_reg <= last_layer;
        end
        if (acc_fire && s1_last_reg)
            pend_total_reg <= sum_upd;
    end

    assign pend.valid = pend_valid_reg;
    assign pend.total = pend_total_reg;

    // The running sum starts over after every shower.
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        acc_fire && s1_last_reg |=> sum_reg == '0)
        else $error("sum not cleared after last layer");

    // A waiting shower sum is never overwritten.
    a_pend_holds: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && !pend_ready |=> pend_valid_reg && $stable(pend_total_reg))
        else $error("pending sum lost");

    // A last layer is only consumed when the pending slot can take it.
    a_last_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        acc_fire && s1_last_reg |-> pend_ready)
        else $error("last layer consumed without a free slot");

endmodule

`default_nettype wire

FILE: rtl/pdc_classify.sv
// Threshold classifier and result register of the profile difference classifier.
// Depends on pdc_pkg; takes a pdc_pkg::pend_t and drives the result channel.
`default_nettype none

module pdc_classify (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pdc_pkg::cfg_t                     cfg,
    input  wire pdc_pkg::pend_t                    pend,
    output logic                                   pend_ready,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [pdc_pkg::CAT_BITS-1:0]           category,
    output logic                                   invalid,
    output logic [pdc_pkg::SUM_BITS-1:0]           total_difference
);

    logic                             out_valid_reg, out_valid_next;
    logic [pdc_pkg::CAT_BITS-1:0]     category_reg;
    logic                             invalid_reg;
    logic [pdc_pkg::SUM_BITS-1:0]     total_reg;

    logic                             out_free;
    logic                             out_load;
    logic [pdc_pkg::THR_USED-1:0]     ge;
    logic                             found;
    logic                             ge_top;
    logic [pdc_pkg::CAT_BITS-1:0]     cat;
    logic                             bad;

    assign out_free   = !out_valid_reg || !out_stall;
    assign out_load   = pend.valid && out_free;
    assign pend_ready = !pend.valid || out_free;

    always_comb
    begin
        for (int i = 0; i < pdc_pkg::THR_USED; i++)
            ge[i] = pend.total >= cfg.thresholds[i];
    end

    // First matching range wins; a sum past the top threshold in use gets the top class.
    always_comb
    begin
        found  = 1'b0;
        cat    = '0;
        bad    = 1'b0;
        ge_top = 1'b0;
        if (!ge[0])
            found = 1'b1;
        for (int i = 0; i < pdc_pkg::THR_USED - 1; i++)
        begin
            if (!found && ((i + 1) < int'(cfg.thr_in_use)) && ge[i] && !ge[i+1])
            begin
                cat   = pdc_pkg::CAT_BITS'(i + 1);
                found = 1'b1;
            end
        end
        for (int i = 0; i < pdc_pkg::THR_USED; i++)
        begin
            if ((i + 1) == int'(cfg.thr_in_use))
                ge_top = ge[i];
        end
        if (!found)
        begin
            if (ge_top)
                cat = pdc_pkg::CAT_BITS'(cfg.thr_in_use);
            else
                bad = 1'b1;
        end
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            category_reg <= cat;
            invalid_reg  <= bad;
            total_reg    <= pend.total;
        end
    end

    assign out_valid        = out_valid_reg;
    assign category         = category_reg;
    assign invalid          = invalid_reg;
    assign total_difference = total_reg;

    // The category field is zero whenever the result is flagged invalid.
    a_invalid_cat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && invalid_reg |-> category_reg == '0)
        else $error("invalid result carries a category");

    // A result register only fills from a waiting shower sum.
    a_load_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(out_valid_reg) && out_valid_reg |-> $past(pend.valid))
        else $error("result appeared without a pending sum");

    // A stalled result stays on the output unchanged.
    a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(total_reg)
            && $stable(category_reg) && $stable(invalid_reg))
        else $error("stalled result changed");

endmodule

`default_nettype wire

FILE: rtl/profile_difference_classifier.sv
// Profile difference classifier: sums |reference - measured| over the layers
// of a shower and classifies the sum against up to four ascending thresholds.
// Input channel: in_valid/in_stall with measured_energy, reference_energy and
// last_layer, one layer per transaction. Output channel: out_valid/out_stall
// with category, invalid and total_difference, one transaction per shower,
// produced for the layer marked last_layer only.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 minimum
// reference, 1 threshold count, 2..5 thresholds a..d); write only while idle.
// Throughput: one layer per cycle while no last layer waits for the pending
// slot, including back-to-back showers. A last layer passes the input register,
// the accumulator with its pending slot and the result register on its way out.
// When the receiver stalls, the result holds and later layers keep flowing
// into the accumulator; only a second finished shower waits in the pending
// slot, and a third last layer then stalls the input.
// Reset clears the running sum, empties every stage, and sets the registers
// to zero except the threshold count, which comes up as four.
// Depends on pdc_pkg, pdc_cfg, pdc_accum and pdc_classify.
`default_nettype none

module profile_difference_classifier (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [pdc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [pdc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [pdc_pkg::ENERGY_BITS-1:0]      measured_energy,
    input  wire logic [pdc_pkg::ENERGY_BITS-1:0]      reference_energy,
    input  wire logic                                 last_layer,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [pdc_pkg::CAT_BITS-1:0]              category,
    output logic                                      invalid,
    output logic [pdc_pkg::SUM_BITS-1:0]              total_difference
);

    pdc_pkg::cfg_t  cfg;
    pdc_pkg::pend_t pend;
    logic           pend_ready;

    pdc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pdc_accum u_accum (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .measured_energy  (measured_energy),
        .reference_energy (reference_energy),
        .last_layer       (last_layer),
        .pend             (pend),
        .pend_ready       (pend_ready)
    );

    pdc_classify u_classify (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .pend             (pend),
        .pend_ready       (pend_ready),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .category         (category),
        .invalid          (invalid),
        .total_difference (total_difference)
    );

endmodule

`default_nettype wire

FILE: tb/sv/profile_difference_classifier_test.sv
// Self-checking testbench for the profile difference classifier: a directed table, then
// randomized showers under several sender and receiver idle patterns, checked by a predictor.
// Depends on pdc_pkg and the profile_difference_classifier RTL only.
`timescale 1ns / 1ps

module profile_difference_classifier_test;

    localparam int LIMIT_CYCLES   = 500000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 200;
    localparam int NUM_PHASES     = 6;
    localparam int SATURATE_PHASE = 2;
    localparam int PRESSURE_PHASE = 4;
    localparam int PHASE_LAYERS   = 110;
    localparam int NUM_STEPS      = 33;
    localparam int THR_INDEX_BITS = $clog2(pdc_pkg::NUM_THR_REGS);

    // Indexes past the register list; writes to them must change nothing.
    localparam logic [pdc_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [pdc_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_7 = 3'd7;

    typedef logic [pdc_pkg::ENERGY_BITS-1:0]    energy_t;
    typedef logic [pdc_pkg::SUM_BITS-1:0]       sum_t;
    typedef logic [pdc_pkg::MINREF_BITS-1:0]    minref_t;
    typedef logic [pdc_pkg::CFG_INDEX_BITS-1:0] reg_index_t;
    typedef logic [pdc_pkg::CFG_DATA_BITS-1:0]  reg_data_t;

    localparam energy_t ENERGY_MAX = '1;

    typedef struct packed {
        logic [pdc_pkg::CAT_BITS-1:0] category;
        logic                         invalid;
        sum_t                         total;
    } shower_class_t;

    typedef enum logic {ROW_LAYER, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        reg_index_t                reg_index;
        reg_data_t                 reg_value;
        energy_t                   meas;
        energy_t                   refe;
        logic                      last;
        logic [9:0]                repeats;
        logic                      typed;
        shower_class_t             want;
    } step_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    reg_index_t                      cfg_index;
    reg_data_t                       cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    energy_t                         measured_energy;
    energy_t                         reference_energy;
    logic                            last_layer;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [pdc_pkg::CAT_BITS-1:0]    category;
    logic                            invalid;
    sum_t                            total_difference;

    // Predictor copy of the registers and the running sum.
    minref_t                         min_ref_cfg;
    logic [pdc_pkg::COUNT_BITS-1:0]  count_cfg;
    sum_t                            thr_cfg [pdc_pkg::NUM_THR_REGS];
    sum_t                            running_sum;

    shower_class_t expected_classes [$];
    shower_class_t next_class;
    int            mismatches  = 0;
    int            cycle_count = 0;
    int            idle_pct    = 0;
    int            stall_pct   = 0;
    int            hold_asked  = 0;
    int            hold_seen   = 0;
    int            hold_left   = 0;

    step_t directed_steps [NUM_STEPS] = '{
        // Reset settings: every threshold is zero, so every shower lands in the top class.
        '{ROW_LAYER, '0, '0, 16'd0,     16'd0,     1'b1, 10'd1, 1'b1, '{3'd4, 1'b0, 24'd0}},
        '{ROW_LAYER, '0, '0, 16'd65535, 16'd0,     1'b1, 10'd1, 1'b1, '{3'd4, 1'b0, 24'd65535}},
        '{ROW_LAYER, '0, '0, 16'd0,     16'd65535, 1'b1, 10'd1, 1'b1, '{3'd4, 1'b0, 24'd65535}},
        '{ROW_LAYER, '0, '0, 16'd100,   16'd300,   1'b0, 10'd1, 1'b0, '0},
        '{ROW_LAYER, '0, '0, 16'd300,   16'd100,   1'b1, 10'd1, 1'b0, '0},
        '{ROW_WRITE, pdc_pkg::CFG_THRESHOLD_A, 24'd1000, '0, '0, 1'b0, '0, 1'b0, '0},
        '{ROW_WRITE, pdc_pkg::CFG_THRESHOLD_B, 24'd2000, '0, '0, 1'b0, '0, 1'b0, '0},
        '{ROW_WRITE, pdc_pkg::CFG_THRESHOLD_C, 24'd3000, '0, '0, 1'b0, '0, 1'b0, '0},
        '{ROW_WRITE, pdc_pkg::CFG_THRESHOLD_D, 24'd4000, '0, '0, 1'b0, '0, 1'b0, '0},
        // Sums just below, between and exactly on the class boundaries.
        '{ROW_LAYER, '0, '0, 16'd0,     16'd999,   1'b1, 10'd1, 1'b1, '{3'd0, 1'b0, 24'd999}},
        '{ROW_LAYER, '0, '0, 16'd0,     16'd1000,  1'b1, 10'd1, 1'b1, '{3'd1, 1'b0, 24'd1000}},
        '{ROW_LAYER, '0, '0, 16'd0,     16'd2500,  1'b1, 10'd1, 1'b1, '{3'd2, 1'b0, 24'd2500}},
        '{ROW_LAYER, '0, '0, 16'd3000,  16'd0,     1'b1, 10'd1, 1'b1, '{3'd3, 1'b0, 24'd3000}},
        // A long shower of full-scale differences drives the sum into saturation.
        '{ROW_LAYER, '0, '0, 16'd65535, 16'd0,     1'b0, 10'd300, 1'b0, '0},
        '{ROW_LAYER, '0, '0, 16'd0,     16'd0,     1'b1, 10'd1, 1'b1, '{3'd4, 1'b0, 24'hFFFFFF}},
        // A threshold count of zero acts as one, a count above four acts as four.
        '{ROW_WRITE, pdc_pkg::CFG_THRESHOLD_COUNT, 24'd0, '0, '0, 1'b0, '0, 1'b0, '0},
        '{ROW_LAYER, '0, '0, 16'd0,     16'd1500,  1'b1, 10'd1, 1'b1, '{3'd1, 1'b0, 24'd1500}},
        '{ROW_WRITE, pdc_pkg::CFG_THRESHOLD_COUNT, 24'd7, '0, '0, 1'b0, '0, 1'b0, '0},
        '{ROW_LAYER, '0, '0, 16'd0,     16'd5000,  1'b1, 10'd1, 1'b1, '{3'd4, 1'b0, 24'd5000}},
        // Highest minimum reference: only a full-scale reference still counts.
        '{ROW_WRITE, pdc_pkg::CFG_MIN_REFERENCE, 24'd65535, '0, '0, 1'b0, '0, 1'b0, '0},
        '{ROW_LAYER, '0, '0, 16'd0,     16'd65534, 1'b0, 10'd1, 1'b0, '0},
        '{ROW_LAYER, '0, '0, 16'd0,     16'd65535, 1'b1, 10'd1, 1'b1, '{3'd4, 1'b0, 24'd65535}},
        '{ROW_WRITE, CFG_SPARE_6, 24'd0, '0, '0, 1'b0, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_SPARE_7, 24'd0, '0, '0, 1'b0, '0, 1'b0, '0},
        '{ROW_LAYER, '0, '0, 16'd0,     16'd65534, 1'b1, 10'd1, 1'b1, '{3'd0, 1'b0, 24'd0}},
        // Thresholds out of order.
        '{ROW_WRITE, pdc_pkg::CFG_MIN_REFERENCE, 24'd0, '0, '0, 1'b0, '0, 1'b0, '0},
        '{ROW_WRITE, pdc_pkg::CFG_THRESHOLD_B, 24'd500, '0, '0, 1'b0, '0, 1'b0, '0},
        '{ROW_LAYER, '0, '0, 16'd1200,  16'd0,     1'b1, 10'd1, 1'b0, '0},
        '{ROW_WRITE, pdc_pkg::CFG_THRESHOLD_A, 24'd0, '0, '0, 1'b0, '0, 1'b0, '0},
        '{ROW_WRITE, pdc_pkg::CFG_THRESHOLD_B, 24'd0, '0, '0, 1'b0, '0, 1'b0, '0},
        '{ROW_WRITE, pdc_pkg::CFG_THRESHOLD_C, 24'd0, '0, '0, 1'b0, '0, 1'b0, '0},
        '{ROW_WRITE, pdc_pkg::CFG_THRESHOLD_D, 24'hFFFFFF, '0, '0, 1'b0, '0, 1'b0, '0},
        '{ROW_LAYER, '0, '0, 16'd65535, 16'd0,     1'b1, 10'd1, 1'b0, '0}
    };

    profile_difference_classifier dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .measured_energy  (measured_energy),
        .reference_energy (reference_energy),
        .last_layer       (last_layer),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .category         (category),
        .invalid          (invalid),
        .total_difference (total_difference)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic shower_class_t classify_sum(input sum_t total);
        shower_class_t verdict;
        int            in_use;
        verdict       = '0;
        verdict.total = total;
        in_use = int'(count_cfg);
        if (in_use < 1)
            in_use = 1;
        if (in_use > pdc_pkg::MAX_THRESHOLDS)
            in_use = pdc_pkg::MAX_THRESHOLDS;
        if (in_use > pdc_pkg::NUM_THR_REGS)
            in_use = pdc_pkg::NUM_THR_REGS;
        if (total < thr_cfg[0])
            return verdict;
        for (int i = 0; i + 1 < in_use; i++)
        begin
            if (total >= thr_cfg[i] && total < thr_cfg[i + 1])
            begin
                verdict.category = pdc_pkg::CAT_BITS'(i + 1);
                return verdict;
            end
        end
        if (total >= thr_cfg[in_use - 1])
            verdict.category = pdc_pkg::CAT_BITS'(in_use);
        else
            verdict.invalid = 1'b1;
        return verdict;
    endfunction

    // Adds one layer to the running sum; returns 1 when the layer closes a shower.
    function automatic bit absorb_layer(input energy_t meas, input energy_t refe,
                                        input logic last, output shower_class_t verdict);
        logic [pdc_pkg::SUM_BITS:0] widened;
        energy_t                    gap;
        verdict = '0;
        if (refe >= min_ref_cfg)
        begin
            gap         = (refe >= meas) ? refe - meas : meas - refe;
            widened     = {1'b0, running_sum} + (pdc_pkg::SUM_BITS + 1)'(gap);
            running_sum = widened[pdc_pkg::SUM_BITS] ? pdc_pkg::SUM_MAX
                                                     : widened[pdc_pkg::SUM_BITS-1:0];
        end
        if (!last)
            return 1'b0;
        verdict     = classify_sum(running_sum);
        running_sum = '0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input sum_t got, input sum_t want);
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic write_reg(input reg_index_t reg_index, input reg_data_t value);
        cfg_we    <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= value;
        @(posedge clk);
        case (reg_index)
            pdc_pkg::CFG_MIN_REFERENCE:
                min_ref_cfg = value[pdc_pkg::MINREF_BITS-1:0];
            pdc_pkg::CFG_THRESHOLD_COUNT:
                count_cfg = value[pdc_pkg::COUNT_BITS-1:0];
            pdc_pkg::CFG_THRESHOLD_A, pdc_pkg::CFG_THRESHOLD_B,
            pdc_pkg::CFG_THRESHOLD_C, pdc_pkg::CFG_THRESHOLD_D:
                thr_cfg[THR_INDEX_BITS'(reg_index - pdc_pkg::CFG_THRESHOLD_A)] =
                    value[pdc_pkg::SUM_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic send_layer(input energy_t meas, input energy_t refe, input logic last,
                              input logic typed, input shower_class_t stated);
        bit            produced;
        shower_class_t verdict;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        measured_energy  <= meas;
        reference_energy <= refe;
        last_layer       <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        produced = absorb_layer(meas, refe, last, verdict);
        if (produced)
            expected_classes.push_back(typed ? stated : verdict);
    endtask

    // Waits until every shower result is back and the pipeline has drained.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_classes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic load_random_setup();
        sum_t        picks [pdc_pkg::NUM_THR_REGS];
        int unsigned level;
        minref_t     floor_value;
        settle();
        case ($urandom_range(7))
            0:       floor_value = '1;
            1:       floor_value = minref_t'($urandom);
            2:       floor_value = minref_t'($urandom_range(1024));
            default: floor_value = '0;
        endcase
        level = $urandom_range(200000);
        for (int i = 0; i < pdc_pkg::NUM_THR_REGS; i++)
        begin
            picks[i] = (level > pdc_pkg::SUM_MAX) ? pdc_pkg::SUM_MAX : sum_t'(level);
            level += $urandom_range(400000);
        end
        case ($urandom_range(7))
            0: foreach (picks[i]) picks[i] = sum_t'($urandom);
            1: foreach (picks[i])
                   picks[i] = (i == pdc_pkg::NUM_THR_REGS - 1) ? pdc_pkg::SUM_MAX : '0;
            2: foreach (picks[i]) picks[i] = pdc_pkg::SUM_MAX;
            default: ;
        endcase
        write_reg(pdc_pkg::CFG_MIN_REFERENCE, reg_data_t'(floor_value));
        write_reg(pdc_pkg::CFG_THRESHOLD_COUNT, reg_data_t'($urandom_range(7)));
        foreach (picks[i])
            write_reg(reg_index_t'(pdc_pkg::CFG_THRESHOLD_A + i), picks[i]);
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? CFG_SPARE_7 : CFG_SPARE_6, reg_data_t'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Receiver: random stalls, or a long hold-off whenever the stimulus asks for one.
    always @(posedge clk)
    begin
        if (hold_seen != hold_asked)
        begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_classes.size() == 0)
                report_mismatch("unexpected transaction, total", total_difference, '0);
            else
            begin
                next_class = expected_classes.pop_front();
                if (category !== next_class.category)
                    report_mismatch("category", sum_t'(category),
                                    sum_t'(next_class.category));
                if (invalid !== next_class.invalid)
                    report_mismatch("invalid", sum_t'(invalid), sum_t'(next_class.invalid));
                if (total_difference !== next_class.total)
                    report_mismatch("total_difference", total_difference, next_class.total);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("profile_difference_classifier_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        bit      writing;
        bit      second_hold;
        bit      saturating;
        int      layers_sent;
        int      shower_len;
        energy_t meas;
        energy_t refe;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = pdc_pkg::CFG_MIN_REFERENCE;
        cfg_data         = '0;
        in_valid         = 1'b0;
        measured_energy  = '0;
        reference_energy = '0;
        last_layer       = 1'b0;
        min_ref_cfg      = '0;
        count_cfg        = pdc_pkg::COUNT_RESET;
        running_sum      = '0;
        foreach (thr_cfg[i])
            thr_cfg[i] = '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        writing = 1'b0;
        foreach (directed_steps[s])
        begin
            if (directed_steps[s].kind == ROW_WRITE)
            begin
                if (!writing)
                    settle();
                write_reg(directed_steps[s].reg_index, directed_steps[s].reg_value);
                writing = 1'b1;
            end
            else
            begin
                if (writing)
                    cfg_we <= 1'b0;
                writing = 1'b0;
                repeat (directed_steps[s].repeats)
                    send_layer(directed_steps[s].meas, directed_steps[s].refe,
                               directed_steps[s].last, directed_steps[s].typed,
                               directed_steps[s].want);
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            load_random_setup();
            case (phase)
                1:
                begin
                    idle_pct = 83;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 83;
                end
                3:
                begin
                    idle_pct = 23;
                    stall_pct <= 23;
                end
                PRESSURE_PHASE:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                    hold_asked <= hold_asked + 1;
                end
                default:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
            endcase
            layers_sent = 0;
            second_hold = 1'b0;
            while (layers_sent < PHASE_LAYERS)
            begin
                if (phase == PRESSURE_PHASE && !second_hold && layers_sent >= PHASE_LAYERS / 2)
                begin
                    hold_asked <= hold_asked + 1;
                    second_hold = 1'b1;
                end
                // The saturation phase opens with a shower long enough to push the sum into saturation.
                saturating = (phase == SATURATE_PHASE) && (layers_sent == 0);
                if (saturating)
                    shower_len = $urandom_range(280, 259);
                else if (phase == PRESSURE_PHASE)
                    shower_len = $urandom_range(2, 1);
                else
                    shower_len = $urandom_range(8, 1);
                for (int k = 0; k < shower_len; k++)
                begin
                    if (saturating)
                    begin
                        meas = energy_t'($urandom_range(255));
                        refe = energy_t'($urandom_range(65535, 65280));
                    end
                    else
                    begin
                        case ($urandom_range(5))
                            0, 1:
                            begin
                                meas = energy_t'($urandom);
                                refe = energy_t'($urandom);
                            end
                            2:
                            begin
                                meas = energy_t'($urandom);
                                refe = meas ^ energy_t'($urandom_range(15));
                            end
                            3:
                            begin
                                meas = $urandom_range(1) ? ENERGY_MAX : '0;
                                refe = $urandom_range(1) ? ENERGY_MAX : '0;
                            end
                            4:
                            begin
                                meas = energy_t'($urandom_range(255));
                                refe = energy_t'($urandom);
                            end
                            default:
                            begin
                                // Reference right around the minimum, on either side of it.
                                meas = energy_t'($urandom);
                                refe = min_ref_cfg - 16'd1 + energy_t'($urandom_range(2));
                            end
                        endcase
                    end
                    send_layer(meas, refe, k == shower_len - 1, 1'b0, '0);
                end
                layers_sent += shower_len;
            end
        end

        settle();
        if (mismatches == 0)
            $display("profile_difference_classifier_test OK");
        else
            $display("profile_difference_classifier_test NOT OK");
        $finish;
    end

endmodule
